// ===== hw/rtl/vertex_transform_persp_div_assert.svh =====
// Assertion macros used by the checker of the vertex transform block.
`ifndef VERTEX_TRANSFORM_PERSP_DIV_ASSERT_SVH
`define VERTEX_TRANSFORM_PERSP_DIV_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define VTPD_ASSERT_SAME(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error("vertex transform assertion failed");

// Consequent checked in the cycle after the antecedent.
`define VTPD_ASSERT_NEXT(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error("vertex transform assertion failed");

`endif

// ===== hw/rtl/vtpd_pkg.sv =====
// Package with types and constants of the vertex transform block.
`timescale 1ns / 1ps
package vtpd_pkg;
   localparam int COORD_FRAC = 8;
   localparam int COEF_FRAC = 12;
   localparam int OUT_FRAC = 16;
   localparam int PLAIN_SHIFT = COORD_FRAC + COEF_FRAC - OUT_FRAC;
   localparam int OUT_WIDTH = 32;
   localparam int NUM_ROWS = 4;
   localparam int NUM_COLS = 4;
   localparam int NUM_LANES = 3;
   localparam int QUOT_BITS = 32;
   localparam int DIV_STEPS = 2;
   localparam int DIV_STAGES = QUOT_BITS / DIV_STEPS;
   localparam int RSP_LATENCY = DIV_STAGES + 4;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int LIMIT_WIDTH = 16;

   typedef logic [2:0] csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0] csr_data_type;
   typedef logic signed [OUT_WIDTH-1:0] out_word_type;

   localparam csr_index_type CSR_COL_ZERO = 3'd0;
   localparam csr_index_type CSR_COL_ONE = 3'd1;
   localparam csr_index_type CSR_COL_TWO = 3'd2;
   localparam csr_index_type CSR_COL_THREE = 3'd3;
   localparam csr_index_type CSR_LIMIT = 3'd4;

   localparam csr_data_type COL_ZERO_RESET = 64'h0000_0000_0000_1000;
   localparam csr_data_type COL_ONE_RESET = 64'h0000_0000_1000_0000;
   localparam csr_data_type COL_TWO_RESET = 64'h0000_1000_0000_0000;
   localparam csr_data_type COL_THREE_RESET = 64'h1000_0000_0000_0000;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'd1049;

   localparam out_word_type OUT_MAX = 32'sh7FFF_FFFF;
   localparam out_word_type OUT_MIN = 32'sh8000_0000;
endpackage

// ===== hw/rtl/vertex_transform_persp_div.sv =====
// Pipelined 4x4 vertex transform with optional perspective divide.
`timescale 1ns / 1ps
//  Channel  Ports                               Handshake
//  request  req_op, req_in_x..req_in_w          start high and busy low
//  result   rsp_out_x..rsp_out_z, rsp_divided,  rsp_valid for one cycle
//           rsp_clipped
//  csr      csr_index, csr_wdata                csr_valid and csr_ready
//
// One transaction enters every cycle; busy is never raised.
// A taken transaction passes through the registers for multiply, sum,
// divide setup, sixteen stages of the restoring divider (two quotient bits
// each) and the output register. Transactions leave in order.
// Reset clears the pipeline valid bits and loads the identity matrix.
module vertex_transform_persp_div #(
   parameter int COORD_WIDTH = 16,
   parameter int COEF_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_op,
   input  logic signed [COORD_WIDTH-1:0] req_in_x,
   input  logic signed [COORD_WIDTH-1:0] req_in_y,
   input  logic signed [COORD_WIDTH-1:0] req_in_z,
   input  logic signed [COORD_WIDTH-1:0] req_in_w,
   output logic                        rsp_valid,
   output vtpd_pkg::out_word_type      rsp_out_x,
   output vtpd_pkg::out_word_type      rsp_out_y,
   output vtpd_pkg::out_word_type      rsp_out_z,
   output logic                        rsp_divided,
   output logic                        rsp_clipped,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  vtpd_pkg::csr_index_type     csr_index,
   input  vtpd_pkg::csr_data_type      csr_wdata
);
   import vtpd_pkg::*;

   localparam int PW = COORD_WIDTH + COEF_WIDTH;
   localparam int SW = PW + 2;
   localparam int MW = PW + 1;
   localparam int XW = (SW > 36) ? SW : 36;
   localparam int NS = DIV_STAGES;

   csr_data_type col_ff [0:NUM_COLS-1];
   logic [LIMIT_WIDTH-1:0] limit_ff;

   logic s1_valid_ff, s1_valid_in, s1_op_ff, s1_op_in;
   logic signed [PW-1:0] s1_prod_ff [0:NUM_COLS-1][0:NUM_ROWS-1];
   logic signed [PW-1:0] s1_prod_in [0:NUM_COLS-1][0:NUM_ROWS-1];

   logic s2_valid_ff, s2_valid_in, s2_op_ff, s2_op_in;
   logic signed [SW-1:0] s2_sum_ff [0:NUM_COLS-1];
   logic signed [SW-1:0] s2_sum_in [0:NUM_COLS-1];

   logic dv_valid_ff [0:NS];
   logic dv_valid_in [0:NS];
   logic dv_div_ff [0:NS];
   logic dv_div_in [0:NS];
   logic [MW-1:0] dv_ud_ff [0:NS];
   logic [MW-1:0] dv_ud_in [0:NS];
   logic [MW-1:0] dv_r_ff [0:NS][0:NUM_LANES-1];
   logic [MW-1:0] dv_r_in [0:NS][0:NUM_LANES-1];
   logic [QUOT_BITS-1:0] dv_q_ff [0:NS][0:NUM_LANES-1];
   logic [QUOT_BITS-1:0] dv_q_in [0:NS][0:NUM_LANES-1];
   logic [QUOT_BITS-1:0] dv_nb_ff [0:NS][0:NUM_LANES-1];
   logic [QUOT_BITS-1:0] dv_nb_in [0:NS][0:NUM_LANES-1];
   logic dv_neg_ff [0:NS][0:NUM_LANES-1];
   logic dv_neg_in [0:NS][0:NUM_LANES-1];
   logic dv_ovf_ff [0:NS][0:NUM_LANES-1];
   logic dv_ovf_in [0:NS][0:NUM_LANES-1];
   out_word_type dv_plain_ff [0:NS][0:NUM_LANES-1];
   out_word_type dv_plain_in [0:NS][0:NUM_LANES-1];
   logic dv_pclip_ff [0:NS][0:NUM_LANES-1];
   logic dv_pclip_in [0:NS][0:NUM_LANES-1];

   logic rsp_valid_ff, rsp_valid_in;
   out_word_type rsp_out_ff [0:NUM_LANES-1];
   out_word_type rsp_out_in [0:NUM_LANES-1];
   logic rsp_divided_ff, rsp_divided_in, rsp_clipped_ff, rsp_clipped_in;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff[0] <= COL_ZERO_RESET;
         col_ff[1] <= COL_ONE_RESET;
         col_ff[2] <= COL_TWO_RESET;
         col_ff[3] <= COL_THREE_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COL_ZERO: col_ff[0] <= csr_wdata;
            CSR_COL_ONE: col_ff[1] <= csr_wdata;
            CSR_COL_TWO: col_ff[2] <= csr_wdata;
            CSR_COL_THREE: col_ff[3] <= csr_wdata;
            CSR_LIMIT: limit_ff <= csr_wdata[LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic signed [COORD_WIDTH-1:0] vert [0:NUM_ROWS-1];
      logic signed [COEF_WIDTH-1:0] coef;
      vert[0] = req_in_x;
      vert[1] = req_in_y;
      vert[2] = req_in_z;
      vert[3] = req_in_w;
      s1_valid_in = start && !busy;
      s1_op_in = req_op;
      for (int c = 0; c < NUM_COLS; c++) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            coef = signed'(col_ff[c][COEF_WIDTH*r +: COEF_WIDTH]);
            s1_prod_in[c][r] = PW'(vert[r] * coef);
         end
      end
   end

   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_op_in = s1_op_ff;
      for (int c = 0; c < NUM_COLS; c++) begin
         s2_sum_in[c] = SW'(s1_prod_ff[c][0]) + SW'(s1_prod_ff[c][1])
                      + SW'(s1_prod_ff[c][2]) + SW'(s1_prod_ff[c][3]);
      end
   end

   always_comb begin
      logic signed [SW-1:0] sw;
      logic signed [SW-1:0] sn;
      logic [MW-1:0] un;
      logic [MW-1:0] ud;
      logic signed [XW-1:0] shr;
      logic [MW:0] t;
      logic [MW-1:0] rr;
      logic [QUOT_BITS-1:0] qq;
      logic [QUOT_BITS-1:0] nb;
      sw = s2_sum_ff[3];
      ud = (sw < 0) ? MW'(-sw) : MW'(sw);
      dv_valid_in[0] = s2_valid_ff;
      dv_div_in[0] = s2_op_ff && (sw != '0)
                   && ({{(MW+LIMIT_WIDTH){1'b0}}, ud} >= {{MW{1'b0}}, limit_ff, {MW{1'b0}}} >> MW);
      dv_ud_in[0] = ud;
      for (int l = 0; l < NUM_LANES; l++) begin
         sn = s2_sum_ff[l];
         un = (sn < 0) ? MW'(-sn) : MW'(sn);
         dv_neg_in[0][l] = (sn < 0) != (sw < 0);
         dv_ovf_in[0][l] = {OUT_FRAC'(0), un} >= {ud, OUT_FRAC'(0)};
         dv_r_in[0][l] = un >> OUT_FRAC;
         dv_q_in[0][l] = '0;
         dv_nb_in[0][l] = {un[OUT_FRAC-1:0], OUT_FRAC'(0)};
         shr = XW'(sn) >>> PLAIN_SHIFT;
         if (!shr[XW-1] && (|shr[XW-2:OUT_WIDTH-1])) begin
            dv_plain_in[0][l] = OUT_MAX;
            dv_pclip_in[0][l] = 1'b1;
         end else if (shr[XW-1] && !(&shr[XW-2:OUT_WIDTH-1])) begin
            dv_plain_in[0][l] = OUT_MIN;
            dv_pclip_in[0][l] = 1'b1;
         end else begin
            dv_plain_in[0][l] = shr[OUT_WIDTH-1:0];
            dv_pclip_in[0][l] = 1'b0;
         end
      end
      for (int k = 1; k <= NS; k++) begin
         dv_valid_in[k] = dv_valid_ff[k-1];
         dv_div_in[k] = dv_div_ff[k-1];
         dv_ud_in[k] = dv_ud_ff[k-1];
         for (int l = 0; l < NUM_LANES; l++) begin
            rr = dv_r_ff[k-1][l];
            qq = dv_q_ff[k-1][l];
            nb = dv_nb_ff[k-1][l];
            for (int s = 0; s < DIV_STEPS; s++) begin
               t = {rr, nb[QUOT_BITS-1]};
               nb = nb << 1;
               if (t >= {1'b0, dv_ud_ff[k-1]}) begin
                  rr = MW'(t - {1'b0, dv_ud_ff[k-1]});
                  qq = {qq[QUOT_BITS-2:0], 1'b1};
               end else begin
                  rr = t[MW-1:0];
                  qq = {qq[QUOT_BITS-2:0], 1'b0};
               end
            end
            dv_r_in[k][l] = rr;
            dv_q_in[k][l] = qq;
            dv_nb_in[k][l] = nb;
            dv_neg_in[k][l] = dv_neg_ff[k-1][l];
            dv_ovf_in[k][l] = dv_ovf_ff[k-1][l];
            dv_plain_in[k][l] = dv_plain_ff[k-1][l];
            dv_pclip_in[k][l] = dv_pclip_ff[k-1][l];
         end
      end
   end

   always_comb begin
      logic clip;
      logic [QUOT_BITS-1:0] q;
      clip = 1'b0;
      rsp_valid_in = dv_valid_ff[NS];
      rsp_divided_in = dv_div_ff[NS];
      for (int l = 0; l < NUM_LANES; l++) begin
         q = dv_q_ff[NS][l];
         if (!dv_div_ff[NS]) begin
            rsp_out_in[l] = dv_plain_ff[NS][l];
            clip = clip | dv_pclip_ff[NS][l];
         end else if (dv_neg_ff[NS][l]) begin
            if (dv_ovf_ff[NS][l] || (q > QUOT_BITS'(OUT_MIN))) begin
               rsp_out_in[l] = OUT_MIN;
               clip = 1'b1;
            end else begin
               rsp_out_in[l] = ~q + 1'b1;
            end
         end else begin
            if (dv_ovf_ff[NS][l] || q[QUOT_BITS-1]) begin
               rsp_out_in[l] = OUT_MAX;
               clip = 1'b1;
            end else begin
               rsp_out_in[l] = q;
            end
         end
      end
      rsp_clipped_in = clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         for (int k = 0; k <= NS; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         for (int k = 0; k <= NS; k++) begin
            dv_valid_ff[k] <= dv_valid_in[k];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff <= s1_op_in;
      s1_prod_ff <= s1_prod_in;
      s2_op_ff <= s2_op_in;
      s2_sum_ff <= s2_sum_in;
      dv_div_ff <= dv_div_in;
      dv_ud_ff <= dv_ud_in;
      dv_r_ff <= dv_r_in;
      dv_q_ff <= dv_q_in;
      dv_nb_ff <= dv_nb_in;
      dv_neg_ff <= dv_neg_in;
      dv_ovf_ff <= dv_ovf_in;
      dv_plain_ff <= dv_plain_in;
      dv_pclip_ff <= dv_pclip_in;
      rsp_out_ff <= rsp_out_in;
      rsp_divided_ff <= rsp_divided_in;
      rsp_clipped_ff <= rsp_clipped_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = rsp_out_ff[0];
   assign rsp_out_y = rsp_out_ff[1];
   assign rsp_out_z = rsp_out_ff[2];
   assign rsp_divided = rsp_divided_ff;
   assign rsp_clipped = rsp_clipped_ff;
endmodule

// ===== hw/rtl/vtpd_checker.sv =====
// Port-level checker of the vertex transform block and its bind.
`timescale 1ns / 1ps
`include "vertex_transform_persp_div_assert.svh"
module vtpd_checker #(
   parameter int COORD_WIDTH = 16
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        req_op,
   input logic signed [COORD_WIDTH-1:0] req_in_x,
   input logic signed [COORD_WIDTH-1:0] req_in_y,
   input logic signed [COORD_WIDTH-1:0] req_in_z,
   input logic signed [COORD_WIDTH-1:0] req_in_w,
   input logic                        rsp_valid,
   input vtpd_pkg::out_word_type      rsp_out_x,
   input vtpd_pkg::out_word_type      rsp_out_y,
   input vtpd_pkg::out_word_type      rsp_out_z,
   input logic                        rsp_divided,
   input logic                        rsp_clipped,
   input logic                        csr_valid,
   input logic                        csr_ready,
   input vtpd_pkg::csr_index_type     csr_index,
   input vtpd_pkg::csr_data_type      csr_wdata
);
   import vtpd_pkg::*;

   `VTPD_ASSERT_NEXT(a_reset_clears, 1'b0, reset, !rsp_valid)
   `VTPD_ASSERT_SAME(a_result_follows, reset, start && !busy, ##RSP_LATENCY rsp_valid)
   `VTPD_ASSERT_SAME(a_no_spurious, reset, rsp_valid, $past(start && !busy, RSP_LATENCY))
   `VTPD_ASSERT_SAME(a_clip_value, reset, rsp_valid && rsp_clipped,
      rsp_out_x == OUT_MAX || rsp_out_x == OUT_MIN || rsp_out_y == OUT_MAX
      || rsp_out_y == OUT_MIN || rsp_out_z == OUT_MAX || rsp_out_z == OUT_MIN)
endmodule

bind vertex_transform_persp_div vtpd_checker #(.COORD_WIDTH(COORD_WIDTH)) u_vtpd_checker (.*);

// ===== bench/vertex_transform_persp_div_test.sv =====
// Self-checking testbench for the vertex transform with perspective divide.
`timescale 1ns / 1ps
module vertex_transform_persp_div_test;
   import vtpd_pkg::*;

   localparam logic OP_PLAIN = 1'b0;
   localparam logic OP_PERSP = 1'b1;

   typedef struct {
      logic [31:0] out_x;
      logic [31:0] out_y;
      logic [31:0] out_z;
      logic divided;
      logic clipped;
   } vertex_result_type;

   class vertex_scoreboard;
      csr_data_type columns[NUM_COLS];
      logic [LIMIT_WIDTH-1:0] near_limit;
      vertex_result_type pending[$];
      int errors;

      function new();
         columns[0] = COL_ZERO_RESET;
         columns[1] = COL_ONE_RESET;
         columns[2] = COL_TWO_RESET;
         columns[3] = COL_THREE_RESET;
         near_limit = LIMIT_RESET;
         errors = 0;
      endfunction

      function void write_register(csr_index_type index, csr_data_type value);
         if (index <= CSR_COL_THREE) begin
            columns[index] = value;
         end else if (index == CSR_LIMIT) begin
            near_limit = value[LIMIT_WIDTH-1:0];
         end
      endfunction

      function longint column_sum(int col, longint vert[4]);
         longint acc;
         acc = 0;
         for (int r = 0; r < NUM_ROWS; r++) begin
            acc += vert[r] * longint'($signed(columns[col][16*r +: 16]));
         end
         return acc;
      endfunction

      function logic [31:0] clamp_word(longint v, inout bit clip);
         if (v > 64'sd2147483647) begin
            clip = 1;
            return OUT_MAX;
         end
         if (v < -64'sd2147483648) begin
            clip = 1;
            return OUT_MIN;
         end
         return v[31:0];
      endfunction

      function logic [31:0] quotient_word(longint n, longint d, inout bit clip);
         bit neg;
         longint un, ud, whole, rem, mag;
         neg = (n < 0) != (d < 0);
         un = (n < 0) ? -n : n;
         ud = (d < 0) ? -d : d;
         whole = un / ud;
         rem = un % ud;
         if (whole >= 65536) begin
            clip = 1;
            return neg ? OUT_MIN : OUT_MAX;
         end
         mag = (whole << OUT_FRAC) + (rem << OUT_FRAC) / ud;
         return clamp_word(neg ? -mag : mag, clip);
      endfunction

      function void note_request(logic op, logic signed [15:0] x, logic signed [15:0] y,
                                 logic signed [15:0] z, logic signed [15:0] w);
         longint vert[4];
         longint sums[3];
         longint sw, wmag;
         bit clip, divide;
         logic [31:0] words[3];
         vertex_result_type res;
         vert[0] = x;
         vert[1] = y;
         vert[2] = z;
         vert[3] = w;
         clip = 0;
         divide = 0;
         for (int c = 0; c < NUM_LANES; c++) sums[c] = column_sum(c, vert);
         if (op == OP_PERSP) begin
            sw = column_sum(3, vert);
            wmag = (sw < 0) ? -sw : sw;
            divide = (sw != 0) && (wmag >= longint'(near_limit));
         end
         for (int c = 0; c < NUM_LANES; c++) begin
            if (divide) words[c] = quotient_word(sums[c], sw, clip);
            else words[c] = clamp_word(sums[c] >>> PLAIN_SHIFT, clip);
         end
         res.out_x = words[0];
         res.out_y = words[1];
         res.out_z = words[2];
         res.divided = divide;
         res.clipped = clip;
         pending.push_back(res);
      endfunction

      function void report(string field, logic [31:0] expected, logic [31:0] actual);
         if (expected !== actual) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, expected,
                     actual);
            errors++;
         end
      endfunction

      function void check_result(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                 logic divided, logic clipped);
         vertex_result_type exp;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h %h %h", $time, x, y, z);
            errors++;
            return;
         end
         exp = pending.pop_front();
         report("out_x", exp.out_x, x);
         report("out_y", exp.out_y, y);
         report("out_z", exp.out_z, z);
         report("divided", exp.divided, divided);
         report("clipped", exp.clipped, clipped);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_op = 1'b0;
   logic signed [15:0] req_in_x = '0;
   logic signed [15:0] req_in_y = '0;
   logic signed [15:0] req_in_z = '0;
   logic signed [15:0] req_in_w = '0;
   logic rsp_valid;
   out_word_type rsp_out_x;
   out_word_type rsp_out_y;
   out_word_type rsp_out_z;
   logic rsp_divided;
   logic rsp_clipped;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = '0;
   csr_data_type csr_wdata = '0;

   vertex_scoreboard vertex_sb = new();
   int quiet_cycles = 0;
   bit idling_on = 1'b1;

   vertex_transform_persp_div DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      bit seen;
      seen = 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            vertex_sb.note_request(req_op, req_in_x, req_in_y, req_in_z, req_in_w);
            seen = 1'b1;
         end
         if (rsp_valid) begin
            vertex_sb.check_result(rsp_out_x, rsp_out_y, rsp_out_z, rsp_divided,
                                   rsp_clipped);
            seen = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            vertex_sb.write_register(csr_index, csr_wdata);
            seen = 1'b1;
         end
         if (quiet_cycles > 2000) begin
            $display("** vertex_transform_persp_div: FAILED **");
            $finish;
         end
         quiet_cycles <= seen ? 0 : quiet_cycles + 1;
      end
   end

   task automatic send_vertex(logic op, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                              logic [15:0] w);
      start <= 1'b1;
      req_op <= op;
      req_in_x <= x;
      req_in_y <= y;
      req_in_z <= z;
      req_in_w <= w;
      do @(posedge clock); while (busy);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (vertex_sb.pending.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type index, csr_data_type value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] random_coord();
      if ($urandom_range(0, 3) == 0) return 16'($signed($urandom_range(0, 1023)) - 512);
      return 16'($urandom);
   endfunction

   function automatic csr_data_type random_column();
      return {$urandom, $urandom};
   endfunction

   task automatic random_vertices(int count);
      for (int i = 0; i < count; i++) begin
         send_vertex(1'($urandom), random_coord(), random_coord(), random_coord(),
                     random_coord());
      end
   endtask

   task automatic extreme_vertices();
      send_vertex(OP_PLAIN, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_vertex(OP_PLAIN, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_vertex(OP_PERSP, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
      send_vertex(OP_PERSP, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
      send_vertex(OP_PERSP, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_vertex(OP_PERSP, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Identity matrix: w of zero, tiny w and full-scale vertices.
      extreme_vertices();
      send_vertex(OP_PERSP, 16'h0100, 16'hFF00, 16'h0080, 16'h0000);
      send_vertex(OP_PERSP, 16'h7FFF, 16'h8000, 16'h0001, 16'h0001);
      send_vertex(OP_PERSP, 16'h0100, 16'h0200, 16'h0300, 16'hFFFF);
      send_vertex(OP_PLAIN, 16'hFFFF, 16'hFFFE, 16'h0001, 16'h0000);
      drain();

      write_csr(CSR_COL_ZERO, random_column());
      write_csr(CSR_COL_ONE, random_column());
      write_csr(CSR_COL_TWO, random_column());
      write_csr(CSR_COL_THREE, random_column());
      write_csr(CSR_LIMIT, csr_data_type'($urandom_range(0, 65535)));
      random_vertices(350);
      drain();

      // Most negative coefficients everywhere, no near-zero limit.
      write_csr(CSR_COL_ZERO, 64'h8000_8000_8000_8000);
      write_csr(CSR_COL_ONE, 64'h8000_8000_8000_8000);
      write_csr(CSR_COL_TWO, 64'h8000_8000_8000_8000);
      write_csr(CSR_COL_THREE, 64'h8000_8000_8000_8000);
      write_csr(CSR_LIMIT, '0);
      extreme_vertices();
      random_vertices(300);
      drain();

      write_csr(CSR_COL_ZERO, 64'h7FFF_7FFF_7FFF_7FFF);
      write_csr(CSR_COL_ONE, 64'h7FFF_8000_7FFF_8000);
      write_csr(CSR_COL_TWO, 64'h0000_0000_0000_0000);
      write_csr(CSR_COL_THREE, 64'h7FFF_7FFF_7FFF_7FFF);
      write_csr(CSR_LIMIT, 64'hFFFF);
      extreme_vertices();
      random_vertices(300);
      drain();

      // Transformed w equals raw x, so small x lands around the limit.
      write_csr(CSR_COL_ZERO, random_column());
      write_csr(CSR_COL_THREE, 64'h0000_0000_0000_0001);
      write_csr(CSR_LIMIT, 64'd300);
      for (int i = 0; i < 300; i++) begin
         send_vertex(OP_PERSP, 16'($signed($urandom_range(0, 1200)) - 600), random_coord(),
                     random_coord(), random_coord());
         if (i == 150) drain();
      end
      drain();

      // Writes past the last register must leave the matrix alone.
      write_csr(csr_index_type'(5), random_column());
      write_csr(csr_index_type'(7), random_column());
      write_csr(CSR_COL_ONE, random_column());
      write_csr(CSR_COL_TWO, random_column());
      write_csr(CSR_COL_THREE, random_column());
      write_csr(CSR_LIMIT, csr_data_type'($urandom_range(0, 4000)));
      idling_on = 1'b0;
      random_vertices(600);
      drain();

      if (vertex_sb.errors == 0 && vertex_sb.pending.size() == 0) begin
         $display("** vertex_transform_persp_div: PASSED **");
      end else begin
         $display("** vertex_transform_persp_div: FAILED **");
      end
      $finish;
   end
endmodule
